FILE: hw/rtl/slfr_pkg.sv
// ----------------------------------------------------------------------------
// slfr_pkg: shared types and constants of the sync/length frame receiver
// Holds the status codes, the result bundle and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package slfr_pkg;

    localparam logic [7:0] SYNC_FIRST     = 8'h55;
    localparam logic [7:0] SYNC_SECOND    = 8'hAA;
    localparam logic [7:0] CRC_POLY       = 8'h1D;
    localparam logic [7:0] MIN_FRAME_LEN  = 8'd5;
    localparam logic [7:0] MAX_LEN_RESET  = 8'd64;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes within the configuration space.
    localparam logic REG_MAX_FRAME_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        ST_HUNT      = 3'd0,
        ST_IN_FRAME  = 3'd1,
        ST_GOOD      = 3'd2,
        ST_CRC_ERROR = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_TOO_SHORT = 3'd5
    } status_t;

    typedef struct packed {
        status_t    status;
        logic       payload_valid;
        logic [7:0] byte_index;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
    } slfr_result_t;

    // One byte of CRC-8 (MSB first, no reflection): eight shift steps.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/slfr_regs.sv
// ----------------------------------------------------------------------------
// slfr_regs: APB register file
// Holds the maximum frame length register, written and read over APB.
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [slfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [slfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [slfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [7:0]                       max_frame_length
);

    logic [7:0] max_len_reg;
    logic [7:0] max_len_next;
    logic       wr_en;
    logic       reg_sel;

    // Registers sit on 32-bit words; the word index is above the byte offset.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en && (reg_sel == slfr_pkg::REG_MAX_FRAME_LENGTH))
        begin
            max_len_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= slfr_pkg::MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb
    begin
        if (reg_sel == slfr_pkg::REG_MAX_FRAME_LENGTH)
        begin
            prdata = {{(slfr_pkg::APB_DATA_W-8){1'b0}}, max_len_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign pready           = 1'b1;
    assign max_frame_length = max_len_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/slfr_parser.sv
// ----------------------------------------------------------------------------
// slfr_parser: frame parser state and per-byte decision logic
// Tracks position, running CRC, length and command, and forms one result.
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_parser (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step_en,
    input  wire logic [7:0]             data_byte,
    input  wire logic [7:0]             max_frame_length,
    output slfr_pkg::slfr_result_t      result
);

    logic [7:0] position_reg;
    logic [7:0] position_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] command_reg;
    logic [7:0] command_next;
    logic [7:0] crc_step;
    logic       last_byte;

    // The CRC seed is zero for the first sync byte, so a cleared running CRC serves.
    assign crc_step  = slfr_pkg::crc8_update((position_reg == 8'd0) ? 8'd0 : crc_reg,
                                             data_byte);
    assign last_byte = ({1'b0, position_reg} + 9'd1) >= {1'b0, length_reg};

    always_comb
    begin
        position_next        = position_reg;
        crc_next             = crc_reg;
        length_next          = length_reg;
        command_next         = command_reg;
        result.status        = slfr_pkg::ST_HUNT;
        result.payload_valid = 1'b0;
        result.byte_index    = position_reg;

        priority if (position_reg == 8'd0)
        begin
            if (data_byte == slfr_pkg::SYNC_FIRST)
            begin
                length_next   = 8'd0;
                command_next  = 8'd0;
                crc_next      = crc_step;
                position_next = 8'd1;
                result.status = slfr_pkg::ST_IN_FRAME;
            end
        end
        else if (position_reg == 8'd1)
        begin
            // A wrong second sync byte is dropped, not taken as a new first sync.
            if (data_byte == slfr_pkg::SYNC_SECOND)
            begin
                crc_next      = crc_step;
                position_next = 8'd2;
                result.status = slfr_pkg::ST_IN_FRAME;
            end
            else
            begin
                crc_next      = 8'd0;
                position_next = 8'd0;
            end
        end
        else if (position_reg == 8'd2)
        begin
            length_next = data_byte;
            priority if (data_byte < slfr_pkg::MIN_FRAME_LEN)
            begin
                result.status = slfr_pkg::ST_TOO_SHORT;
                crc_next      = 8'd0;
                position_next = 8'd0;
            end
            else if (data_byte > max_frame_length)
            begin
                result.status = slfr_pkg::ST_TOO_LONG;
                crc_next      = 8'd0;
                position_next = 8'd0;
            end
            else
            begin
                crc_next      = crc_step;
                position_next = 8'd3;
                result.status = slfr_pkg::ST_IN_FRAME;
            end
        end
        else if (position_reg == 8'd3)
        begin
            command_next  = data_byte;
            crc_next      = crc_step;
            position_next = 8'd4;
            result.status = slfr_pkg::ST_IN_FRAME;
        end
        else if (last_byte)
        begin
            result.status = (data_byte == crc_reg) ? slfr_pkg::ST_GOOD
                                                   : slfr_pkg::ST_CRC_ERROR;
            crc_next      = 8'd0;
            position_next = 8'd0;
        end
        else
        begin
            result.payload_valid = 1'b1;
            crc_next             = crc_step;
            position_next        = position_reg + 8'd1;
            result.status        = slfr_pkg::ST_IN_FRAME;
        end

        result.frame_command = command_next;
        result.frame_length  = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= 8'd0;
            crc_reg      <= 8'd0;
            length_reg   <= 8'd0;
            command_reg  <= 8'd0;
        end
        else if (step_en)
        begin
            position_reg <= position_next;
            crc_reg      <= crc_next;
            length_reg   <= length_next;
            command_reg  <= command_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sync_length_frame_receiver_crc8.sv
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_crc8: sync/length framed receiver with CRC-8
// Hunts for 0x55 0xAA, checks length and CRC-8 (poly 0x1D), passes bytes on.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes arrive on the input channel (in_valid, in_stall, rx_byte).
// Each byte gives exactly one result transfer on the output channel
// (out_valid, out_stall and the result fields): status, the byte itself, a
// payload flag, its index in the frame and the frame's length and command.
// A byte is captured in an input register; the parser decides on it once
// the result register is empty or being emptied, and loads the result register.
// The block takes one byte every cycle while the output is not stalled; the
// parser's one-byte CRC update sits between the two registers.
// When the receiver stalls, the result register holds and the input register
// keeps one more byte; after that in_stall is raised until the stall clears.
// Reset empties both registers, returns the parser to hunting with a zero CRC,
// length and command, and sets max_frame_length to 64. The user must write the
// register over APB only while no byte is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_frame_receiver_crc8 (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       rx_byte,
    // output channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [2:0]                       status,
    output logic      [7:0]                       byte_out,
    output logic                                  payload_valid,
    output logic      [7:0]                       byte_index,
    output logic      [7:0]                       frame_command,
    output logic      [7:0]                       frame_length,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [slfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [slfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [slfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    slfr_pkg::slfr_result_t res_reg;
    logic [7:0]             byte_out_reg;
    slfr_pkg::slfr_result_t step_result;
    logic [7:0]             max_frame_length;
    logic                   step_en;
    logic                   in_load;

    slfr_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .max_frame_length (max_frame_length)
    );

    // The held byte moves on whenever the result register is empty or its
    // current transfer completes in this cycle.
    assign step_en  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step_en;
    assign in_load  = in_valid && !in_stall;

    slfr_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (step_en),
        .data_byte        (in_byte_reg),
        .max_frame_length (max_frame_length),
        .result           (step_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg      <= step_result;
            byte_out_reg <= in_byte_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign byte_out      = byte_out_reg;
    assign payload_valid = res_reg.payload_valid;
    assign byte_index    = res_reg.byte_index;
    assign frame_command = res_reg.frame_command;
    assign frame_length  = res_reg.frame_length;

endmodule

`default_nettype wire

FILE: tb/slfr_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slfr_frame_checker: result predictor and comparator for the frame receiver
// Watches the byte, result and APB channels, predicts each result in order
// and counts every difference against the block's outputs.
// ----------------------------------------------------------------------------

module slfr_frame_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [2:0]                       status,
    input  wire logic [7:0]                       byte_out,
    input  wire logic                             payload_valid,
    input  wire logic [7:0]                       byte_index,
    input  wire logic [7:0]                       frame_command,
    input  wire logic [7:0]                       frame_length,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [slfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [slfr_pkg::APB_DATA_W-1:0]  pwdata,
    input  wire logic [slfr_pkg::APB_DATA_W-1:0]  prdata,
    input  wire logic                             pready,
    output int                                    mismatches,
    output int                                    outstanding
);

    typedef struct packed {
        slfr_pkg::status_t status;
        logic [7:0]        data;
        logic              payload;
        logic [7:0]        index;
        logic [7:0]        command;
        logic [7:0]        length;
    } byte_result_t;

    logic [7:0]   crc_table [256];
    logic [7:0]   max_len;
    logic [7:0]   position;
    logic [7:0]   crc_acc;
    logic [7:0]   len_held;
    logic [7:0]   cmd_held;
    byte_result_t parsed_bytes_q [$];

    initial
    begin
        logic [7:0] v;
        for (int i = 0; i < 256; i++)
        begin
            v = 8'(i);
            for (int k = 0; k < 8; k++)
            begin
                v = v[7] ? ({v[6:0], 1'b0} ^ slfr_pkg::CRC_POLY) : {v[6:0], 1'b0};
            end
            crc_table[i] = v;
        end
        mismatches  = 0;
        outstanding = 0;
    end

    // Advances the parser by one received byte and returns what it reports.
    function automatic byte_result_t parse_rx_byte(input logic [7:0] b);
        byte_result_t r;
        r.status  = slfr_pkg::ST_HUNT;
        r.data    = b;
        r.payload = 1'b0;
        r.index   = position;
        if (position == 8'd0)
        begin
            if (b == slfr_pkg::SYNC_FIRST)
            begin
                len_held = 8'd0;
                cmd_held = 8'd0;
                crc_acc  = crc_table[b];
                position = 8'd1;
                r.status = slfr_pkg::ST_IN_FRAME;
            end
        end
        else if (position == 8'd1)
        begin
            // A bad second sync byte is dropped, not retried as a first one.
            if (b == slfr_pkg::SYNC_SECOND)
            begin
                crc_acc  = crc_table[crc_acc ^ b];
                position = 8'd2;
                r.status = slfr_pkg::ST_IN_FRAME;
            end
            else
            begin
                crc_acc  = 8'd0;
                position = 8'd0;
            end
        end
        else if (position == 8'd2)
        begin
            len_held = b;
            if (b < slfr_pkg::MIN_FRAME_LEN)
            begin
                r.status = slfr_pkg::ST_TOO_SHORT;
                crc_acc  = 8'd0;
                position = 8'd0;
            end
            else if (b > max_len)
            begin
                r.status = slfr_pkg::ST_TOO_LONG;
                crc_acc  = 8'd0;
                position = 8'd0;
            end
            else
            begin
                crc_acc  = crc_table[crc_acc ^ b];
                position = 8'd3;
                r.status = slfr_pkg::ST_IN_FRAME;
            end
        end
        else if (position == 8'd3)
        begin
            cmd_held = b;
            crc_acc  = crc_table[crc_acc ^ b];
            position = 8'd4;
            r.status = slfr_pkg::ST_IN_FRAME;
        end
        else if ({1'b0, position} + 9'd1 >= {1'b0, len_held})
        begin
            r.status = (b == crc_acc) ? slfr_pkg::ST_GOOD : slfr_pkg::ST_CRC_ERROR;
            crc_acc  = 8'd0;
            position = 8'd0;
        end
        else
        begin
            r.payload = 1'b1;
            crc_acc   = crc_table[crc_acc ^ b];
            position  = position + 8'd1;
            r.status  = slfr_pkg::ST_IN_FRAME;
        end
        r.command = cmd_held;
        r.length  = len_held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        byte_result_t want;
        byte_result_t got;
        if (!rst_n)
        begin
            max_len  = slfr_pkg::MAX_LEN_RESET;
            position = 8'd0;
            crc_acc  = 8'd0;
            len_held = 8'd0;
            cmd_held = 8'd0;
            parsed_bytes_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pready &&
                paddr[slfr_pkg::APB_ADDR_W-1:2] == slfr_pkg::REG_MAX_FRAME_LENGTH)
            begin
                if (pwrite)
                begin
                    max_len = pwdata[7:0];
                end
                else if (prdata[7:0] !== max_len)
                begin
                    mismatches++;
                    $display("%0t: max_frame_length read, expected %02h, got %02h",
                             $time, max_len, prdata[7:0]);
                end
            end

            if (in_valid && !in_stall)
                parsed_bytes_q.push_back(parse_rx_byte(rx_byte));

            if (out_valid && !out_stall)
            begin
                got = '{slfr_pkg::status_t'(status), byte_out, payload_valid, byte_index,
                        frame_command, frame_length};
                if (parsed_bytes_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, %s %0d %02h %0d %02h %02h %02h",
                             $time, "got", got.status, got.data, got.payload, got.index,
                             got.command, got.length);
                end
                else
                begin
                    want = parsed_bytes_q.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.payload !== want.payload || got.index !== want.index ||
                        got.command !== want.command || got.length !== want.length)
                    begin
                        mismatches++;
                        $write("%0t: result (status byte payload index cmd len) ", $time);
                        $write("expected %0d %02h %0d %02h %02h %02h, ",
                               want.status, want.data, want.payload, want.index,
                               want.command, want.length);
                        $display("got %0d %02h %0d %02h %02h %02h",
                                 got.status, got.data, got.payload, got.index,
                                 got.command, got.length);
                    end
                end
            end
            outstanding = parsed_bytes_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top of the sync/length frame receiver with CRC-8
// Drives received bytes and random back-pressure, programs the maximum frame
// length over APB between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb;

    // Cycles without any transfer before the run is declared hung. The longest
    // legal quiet stretch is the receiver hold-off plus the usual random gaps.
    localparam int unsigned IDLE_LIMIT   = 2000;
    // Length of the receiver hold-off that backs the block up into its input.
    localparam int unsigned HOLD_CYCLES  = 48;
    // Bytes sent per configuration phase; six phases give roughly 2000 bytes.
    localparam int unsigned PHASE_BYTES  = 330;
    // Index of a register slot that does not exist; writes to it are dropped.
    localparam int unsigned UNMAPPED_REG = 1;

    localparam logic [slfr_pkg::APB_ADDR_W-1:0] ADDR_MAX_LEN  =
        {slfr_pkg::REG_MAX_FRAME_LENGTH, 2'b00};
    localparam logic [slfr_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = 4 * UNMAPPED_REG;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      rx_byte;
    logic                            out_valid;
    logic                            out_stall;
    logic [2:0]                      status;
    logic [7:0]                      byte_out;
    logic                            payload_valid;
    logic [7:0]                      byte_index;
    logic [7:0]                      frame_command;
    logic [7:0]                      frame_length;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [slfr_pkg::APB_ADDR_W-1:0] paddr;
    logic [slfr_pkg::APB_DATA_W-1:0] pwdata;
    logic [slfr_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int                              mismatches;
    int                              pending;

    // Stimulus bookkeeping: the maximum length the block is currently
    // programmed with, so that frames can be aimed at either side of it.
    logic [7:0]                      cur_max;
    int unsigned                     bytes_sent;
    bit                              sender_calm;
    int unsigned                     quiet_cycles;

    sync_length_frame_receiver_crc8 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .byte_out      (byte_out),
        .payload_valid (payload_valid),
        .byte_index    (byte_index),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    slfr_frame_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .byte_out      (byte_out),
        .payload_valid (payload_valid),
        .byte_index    (byte_index),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frame CRC for the stimulus side, fed one data bit at a time.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0} ^ (fb ? slfr_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Offers one byte after a random gap and returns once the transfer has
    // happened. All input changes happen at the falling edge. Every 50 bytes
    // the sender decides whether to run back to back for a while.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        if (bytes_sent % 50 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            rx_byte  = $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Both sync bytes and the length byte.
    task automatic send_header(input logic [7:0] flen);
        send_byte(slfr_pkg::SYNC_FIRST);
        send_byte(slfr_pkg::SYNC_SECOND);
        send_byte(flen);
    endtask

    // A complete frame with random payload; the CRC byte can be corrupted.
    task automatic send_frame(input logic [7:0] flen, input logic [7:0] cmd, input bit bad_crc);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc8_next(8'h00, slfr_pkg::SYNC_FIRST);
        crc = crc8_next(crc, slfr_pkg::SYNC_SECOND);
        crc = crc8_next(crc, flen);
        crc = crc8_next(crc, cmd);
        send_header(flen);
        send_byte(cmd);
        for (int k = 4; k < flen - 1; k++)
        begin
            b   = $urandom;
            crc = crc8_next(crc, b);
            send_byte(b);
        end
        send_byte(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
    endtask

    // Drops valid once the last offered byte has been taken.
    task automatic stop_sending();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Waits until every byte sent so far has produced its result, then lets
    // the pipeline drain.
    task automatic wait_idle();
        stop_sending();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(input logic write,
                              input logic [slfr_pkg::APB_ADDR_W-1:0] addr,
                              input logic [slfr_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Programs a new maximum length and reads it back; the checker compares
    // the read data with its own copy.
    task automatic set_max_len(input logic [7:0] value);
        wait_idle();
        apb_access(1'b1, ADDR_MAX_LEN, {{(slfr_pkg::APB_DATA_W-8){1'b0}}, value});
        cur_max = value;
        apb_access(1'b0, ADDR_MAX_LEN, '0);
    endtask

    // Pick a frame length that is valid under the current setting; most are
    // short, a few sit right at the maximum.
    function automatic logic [7:0] pick_length();
        if ($urandom_range(0, 19) == 0)
            return cur_max;
        return $urandom_range(5, (cur_max < 8'd16) ? cur_max : 16);
    endfunction

    // Random traffic. Most of it is frames with random content, some with a
    // corrupted CRC, so that the parser gets past the header; the rest is
    // rejected lengths, broken sync pairs, cut-off frames and line noise.
    task automatic random_traffic(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        logic [7:0]  flen;
        start = bytes_sent;
        while (bytes_sent - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_frame(pick_length(), $urandom, $urandom_range(0, 9) == 0);
            end
            else if (pick < 77)
            begin
                send_header($urandom_range(0, 4));
            end
            else if (pick < 84)
            begin
                // Too long: just above the limit half of the time; too short at a maximum of 255.
                if (cur_max < 8'd255)
                begin
                    if ($urandom_range(0, 1) == 0)
                        flen = cur_max + 8'd1;
                    else
                        flen = $urandom_range(cur_max + 1, 255);
                end
                else
                begin
                    flen = $urandom_range(0, 4);
                end
                send_header(flen);
            end
            else if (pick < 91)
            begin
                send_byte(slfr_pkg::SYNC_FIRST);
                send_byte($urandom);
            end
            else if (pick < 96)
            begin
                // A frame cut short; later bytes are taken as its remainder.
                flen = pick_length();
                send_header(flen);
                repeat ($urandom_range(0, flen - 4)) send_byte($urandom);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_byte($urandom);
            end
        end
    endtask

    // Result side: a random stall before every result transfer, with calm
    // stretches, and two long hold-offs that make the block fill up and
    // raise in_stall while the sender keeps offering bytes.
    initial
    begin
        int unsigned taken;
        int unsigned delay;
        bit          calm;
        out_stall = 1'b0;
        taken     = 0;
        calm      = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (taken == 400 || taken == 1500)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            delay = calm ? 0 : $urandom_range(0, 6);
            if (delay != 0)
            begin
                out_stall = 1'b1;
                repeat (delay) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    // Watchdog: any transfer on either channel, or APB activity, counts as
    // progress. A long stretch without any means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cur_max      = slfr_pkg::MAX_LEN_RESET;
        bytes_sent   = 0;
        sender_calm  = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // The reset value of the maximum length is checked on read-back.
        apb_access(1'b0, ADDR_MAX_LEN, '0);

        // Directed part, under the reset maximum of 64.
        // Line noise at both byte extremes while hunting.
        send_byte(8'h00);
        send_byte(8'hFF);
        // A wrong second sync byte: the second 0x55 is dropped rather than
        // taken as a new start, so the 0xAA after it is plain noise.
        send_byte(slfr_pkg::SYNC_FIRST);
        send_byte(slfr_pkg::SYNC_FIRST);
        send_byte(slfr_pkg::SYNC_SECOND);
        // Shortest legal frame, a frame with payload, and a CRC error.
        send_frame(8'd5, 8'h00, 1'b0);
        send_frame(8'd7, 8'hFF, 1'b0);
        send_frame(8'd5, 8'hA5, 1'b1);
        // Length one below the minimum, then the largest length byte, which
        // is above the maximum. Both end the frame at the length byte.
        send_header(8'd4);
        send_header(8'hFF);

        // Random phases over several settings, the extremes included.
        random_traffic(PHASE_BYTES);
        set_max_len(8'd5);
        random_traffic(PHASE_BYTES);
        set_max_len(8'd255);
        random_traffic(PHASE_BYTES);
        set_max_len($urandom_range(6, 254));
        random_traffic(PHASE_BYTES);

        // A write to an unmapped slot must leave the maximum untouched; the
        // read-back afterwards confirms it.
        wait_idle();
        apb_access(1'b1, ADDR_UNMAPPED, $urandom);
        apb_access(1'b0, ADDR_MAX_LEN, '0);
        random_traffic(PHASE_BYTES);

        set_max_len($urandom_range(5, 20));
        random_traffic(PHASE_BYTES);

        // Drain: every result must arrive, then a further wait catches any
        // stray result the block might still put out.
        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
